// File: rtl/core/dual_waveform_tone_generator_top_macros.svh
// Assertion helpers for the tone generator.
`ifndef DUAL_WAVEFORM_TONE_GENERATOR_TOP_MACROS_SVH
`define DUAL_WAVEFORM_TONE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DWTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DWTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dwtg_pkg.sv
package dwtg_pkg;

  localparam int FREQ_W  = 17;
  localparam int PHASE_W = 20;
  localparam int HP_W    = 19;
  localparam int SMP_W   = 16;

  localparam logic [PHASE_W-1:0] PHASE_MOD     = 20'd705600;
  localparam logic [PHASE_W-1:0] PHASE_HALF    = 20'd352800;
  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 20'd176400;
  localparam logic [31:0]        HALF_PI_Q30   = 32'd1686629713;
  localparam logic [31:0]        Q30_ONE       = 32'h4000_0000;
  localparam logic [31:0]        AMPLITUDE     = 32'd32760;
  localparam logic [31:0]        CIRC_GAIN     = 32'd65520;
  localparam logic [42:0]        CIRC_OFFSET   = 43'd32760 << 26;

  // Angle scale split as q*A_COEF + floor(q*A_REM/PHASE_QUARTER)
  localparam logic [31:0] A_COEF = HALF_PI_Q30 / 32'(PHASE_QUARTER);
  localparam logic [31:0] A_REM  = HALF_PI_Q30 - A_COEF * 32'(PHASE_QUARTER);
  // PHASE_QUARTER is 16 * A_DIV, so the remainder term is divided in two steps
  localparam logic [31:0] A_DIV  = 32'(PHASE_QUARTER >> 4);

  // Reciprocals floor(2^32/d) for the constant divisions
  localparam logic [63:0] TWO_POW_32  = 64'h1_0000_0000;
  localparam logic [31:0] SERIES_DIV0 = 32'd156;
  localparam logic [31:0] RECIP_DIV0  = 32'(TWO_POW_32 / 64'd156);
  localparam logic [31:0] RECIP_A_DIV = 32'(TWO_POW_32 / 64'(A_DIV));

  // Horner divisors for the sine series, in order of use.
  function automatic logic [7:0] horner_div(input logic [2:0] idx);
    case (idx)
      3'd0: horner_div = 8'd110;
      3'd1: horner_div = 8'd72;
      3'd2: horner_div = 8'd42;
      3'd3: horner_div = 8'd20;
      3'd4: horner_div = 8'd6;
      default: horner_div = 8'd6;
    endcase
  endfunction

  // Matching reciprocals of the Horner divisors.
  function automatic logic [31:0] horner_recip(input logic [2:0] idx);
    case (idx)
      3'd0: horner_recip = 32'(TWO_POW_32 / 64'd110);
      3'd1: horner_recip = 32'(TWO_POW_32 / 64'd72);
      3'd2: horner_recip = 32'(TWO_POW_32 / 64'd42);
      3'd3: horner_recip = 32'(TWO_POW_32 / 64'd20);
      3'd4: horner_recip = 32'(TWO_POW_32 / 64'd6);
      default: horner_recip = 32'(TWO_POW_32 / 64'd6);
    endcase
  endfunction

endpackage

// File: rtl/core/dual_waveform_tone_generator_top.sv
// Processing an item uses up to two 64-step divisions on the shared restoring
// divider, a 27-step square root, seven constant divisions (reciprocal multiply,
// fix, adjust) and steps on the shared 32x32 multiplier.
// A new item is accepted only once the previous one has reached the output
// register, and later while that register is held by smp_stall.
// Reset (rst, synchronous) clears tone state and empties the output register.
`include "dual_waveform_tone_generator_top_macros.svh"

module dual_waveform_tone_generator_top
  import dwtg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [FREQ_W-1:0]       tone_freq,
  input  logic                    tone_start,
  output logic                    smp_valid,
  input  logic                    smp_stall,
  output logic signed [SMP_W-1:0] sine_sample,
  output logic signed [SMP_W-1:0] circle_sample
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV     = 5'd1;
  localparam logic [4:0] S_HP      = 5'd2;
  localparam logic [4:0] S_CHECK   = 5'd3;
  localparam logic [4:0] S_MUL_A   = 5'd4;
  localparam logic [4:0] S_A       = 5'd5;
  localparam logic [4:0] S_MUL_A2  = 5'd6;
  localparam logic [4:0] S_T       = 5'd7;
  localparam logic [4:0] S_MUL_T   = 5'd8;
  localparam logic [4:0] S_T2      = 5'd9;
  localparam logic [4:0] S_MUL_S   = 5'd10;
  localparam logic [4:0] S_MUL_MAG = 5'd11;
  localparam logic [4:0] S_MUL_M   = 5'd12;
  localparam logic [4:0] S_MUL_PP  = 5'd13;
  localparam logic [4:0] S_R       = 5'd14;
  localparam logic [4:0] S_SQRT    = 5'd15;
  localparam logic [4:0] S_MUL_H   = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;
  localparam logic [4:0] S_CD_MUL  = 5'd18;
  localparam logic [4:0] S_CD_FIX  = 5'd19;
  localparam logic [4:0] S_CD_ADJ  = 5'd20;

  logic [4:0]         state;
  logic [4:0]         ret_state;
  logic [FREQ_W-1:0]  cur_freq;
  logic [HP_W-1:0]    half_period;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] pos;
  logic               neg;
  logic [17:0]        q;
  logic [31:0]        a;
  logic [31:0]        a2;
  logic [31:0]        t;
  logic [2:0]         idx;
  logic [36:0]        m;
  logic [SMP_W-1:0]   sine_res;
  logic [SMP_W-1:0]   circ_res;

  // Shared restoring divider
  logic [63:0] div_quo;
  logic [39:0] div_rem;
  logic [39:0] div_den;
  logic [6:0]  div_cnt;
  logic [40:0] rem_sh;
  logic        rem_ge;

  // Constant divider: reciprocal estimate, then one correction step
  logic [31:0] cd_n;
  logic [31:0] cd_r;
  logic [31:0] cd_d;
  logic [31:0] cd_q;
  logic [31:0] cd_rem;

  // Square root unit
  logic [53:0] sq_v;
  logic [53:0] sq_r;
  logic [53:0] sq_bit;
  logic [4:0]  sq_cnt;
  logic [53:0] sq_try;

  // Shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // Phase fold and wrap terms
  logic [PHASE_W-1:0] span;
  logic [PHASE_W-1:0] ph_w;
  logic [PHASE_W-1:0] pos_w;
  logic [PHASE_W-1:0] qa;
  logic [PHASE_W-1:0] qb;
  logic [PHASE_W-1:0] ph_adv;
  logic [PHASE_W-1:0] pos_adv;
  logic [42:0]        circ_p;
  logic [42:0]        circ_d;
  logic [31:0]        s_val;

  assign req_stall = (state != S_IDLE);

  assign rem_sh = {div_rem, div_quo[63]};
  assign rem_ge = (rem_sh >= {1'b0, div_den});
  assign sq_try = sq_r + sq_bit;

  // Operand select for the multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A:   begin mul_a = {14'd0, q};  mul_b = A_REM;       end
      S_A:       begin mul_a = {14'd0, q};  mul_b = A_COEF;      end
      S_MUL_A2:  begin mul_a = a;           mul_b = a;           end
      S_MUL_T:   begin mul_a = a2;          mul_b = t;           end
      S_CD_MUL:  begin mul_a = cd_n;        mul_b = cd_r;        end
      S_CD_FIX:  begin mul_a = cd_q;        mul_b = cd_d;        end
      S_MUL_S:   begin mul_a = a;           mul_b = t;           end
      S_MUL_MAG: begin mul_a = AMPLITUDE;   mul_b = t;           end
      S_MUL_M:   begin mul_a = {12'd0, pos}; mul_b = {12'd0, span - pos}; end
      S_MUL_PP:  begin mul_a = {13'd0, half_period}; mul_b = {13'd0, half_period}; end
      S_MUL_H:   begin mul_a = CIRC_GAIN;   mul_b = sq_r[31:0];  end
      default:   begin mul_a = '0;          mul_b = '0;          end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Wrap, fold and advance terms
  always_comb begin
    span    = {half_period, 1'b0};
    ph_w    = (phase >= PHASE_MOD) ? '0 : phase;
    pos_w   = (pos >= span) ? '0 : pos;
    qa      = (ph_w >= PHASE_HALF) ? (ph_w - PHASE_HALF) : ph_w;
    qb      = (qa > PHASE_QUARTER) ? (PHASE_HALF - qa) : qa;
    ph_adv  = phase + PHASE_W'(cur_freq);
    if (ph_adv >= PHASE_MOD) ph_adv = ph_adv - PHASE_MOD;
    pos_adv = pos + 1'b1;
    if (pos_adv >= span) pos_adv = '0;
    circ_p  = prod[42:0];
    circ_d  = (circ_p >= CIRC_OFFSET) ? (circ_p - CIRC_OFFSET)
                                      : (CIRC_OFFSET - circ_p);
    s_val   = (prod[63:30] > 34'(Q30_ONE)) ? Q30_ONE : prod[61:30];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret_state   <= S_IDLE;
      cur_freq    <= '0;
      half_period <= '0;
      phase       <= '0;
      pos         <= '0;
      smp_valid   <= 1'b0;
      div_cnt     <= '0;
      sq_cnt      <= '0;
      idx         <= '0;
    end else begin
      if (smp_valid && !smp_stall && state != S_DONE) smp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (tone_start) begin
              cur_freq <= tone_freq;
              phase    <= '0;
              pos      <= '0;
              if (tone_freq != '0) begin
                div_quo   <= 64'(PHASE_HALF);
                div_rem   <= '0;
                div_den   <= 40'(tone_freq);
                div_cnt   <= 7'd64;
                ret_state <= S_HP;
                state     <= S_DIV;
              end else begin
                half_period <= '0;
                state       <= S_CHECK;
              end
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_DIV: begin
          div_rem <= rem_ge ? 40'(rem_sh - {1'b0, div_den}) : rem_sh[39:0];
          div_quo <= {div_quo[62:0], rem_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == 7'd1) state <= ret_state;
        end
        S_CD_MUL: begin
          cd_q  <= prod[63:32];
          state <= S_CD_FIX;
        end
        S_CD_FIX: begin
          cd_rem <= cd_n - prod[31:0];
          state  <= S_CD_ADJ;
        end
        S_CD_ADJ: begin
          if (cd_rem >= cd_d) cd_q <= cd_q + 1'b1;
          state <= ret_state;
        end
        S_HP: begin
          half_period <= div_quo[HP_W-1:0];
          state       <= S_CHECK;
        end
        S_CHECK: begin
          if (cur_freq != '0 && half_period >= HP_W'(2)) begin
            phase <= ph_w;
            pos   <= pos_w;
            neg   <= (ph_w >= PHASE_HALF);
            q     <= qb[17:0];
            state <= S_MUL_A;
          end else begin
            sine_res <= '0;
            circ_res <= '0;
            state    <= S_DONE;
          end
        end
        S_MUL_A: begin
          cd_n      <= {2'd0, prod[33:4]};
          cd_r      <= RECIP_A_DIV;
          cd_d      <= A_DIV;
          ret_state <= S_A;
          state     <= S_CD_MUL;
        end
        S_A: begin
          a     <= prod[31:0] + cd_q;
          state <= S_MUL_A2;
        end
        S_MUL_A2: begin
          a2        <= prod[61:30];
          cd_n      <= prod[61:30];
          cd_r      <= RECIP_DIV0;
          cd_d      <= SERIES_DIV0;
          ret_state <= S_T;
          state     <= S_CD_MUL;
        end
        S_T: begin
          t     <= Q30_ONE - cd_q;
          idx   <= '0;
          state <= S_MUL_T;
        end
        S_MUL_T: begin
          cd_n      <= prod[61:30];
          cd_r      <= horner_recip(idx);
          cd_d      <= 32'(horner_div(idx));
          ret_state <= S_T2;
          state     <= S_CD_MUL;
        end
        S_T2: begin
          t <= Q30_ONE - cd_q;
          if (idx == 3'd4) begin
            state <= S_MUL_S;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL_T;
          end
        end
        S_MUL_S: begin
          t     <= s_val;
          state <= S_MUL_MAG;
        end
        S_MUL_MAG: begin
          sine_res <= neg ? (16'd0 - prod[45:30]) : prod[45:30];
          state    <= S_MUL_M;
        end
        S_MUL_M: begin
          m     <= prod[36:0];
          state <= S_MUL_PP;
        end
        S_MUL_PP: begin
          div_quo   <= {1'b0, m, 26'd0};
          div_rem   <= '0;
          div_den   <= {3'd0, prod[36:0]};
          div_cnt   <= 7'd64;
          ret_state <= S_R;
          state     <= S_DIV;
        end
        S_R: begin
          sq_v   <= {div_quo[27:0], 26'd0};
          sq_r   <= '0;
          sq_bit <= 54'd1 << 52;
          sq_cnt <= 5'd27;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt - 1'b1;
          if (sq_cnt == 5'd1) state <= S_MUL_H;
        end
        S_MUL_H: begin
          circ_res <= (circ_p >= CIRC_OFFSET) ? circ_d[41:26] : (16'd0 - circ_d[41:26]);
          phase    <= ph_adv;
          pos      <= pos_adv;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!smp_valid || !smp_stall) begin
            smp_valid     <= 1'b1;
            sine_sample   <= sine_res;
            circle_sample <= circ_res;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `DWTG_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "input not held")
  `DWTG_ASSERT_NOW(a_div_count_live, state == S_DIV, div_cnt != 7'd0, "divider count zero")
  `DWTG_ASSERT_NOW(a_hp_min, state == S_CHECK && cur_freq != '0, half_period >= HP_W'(2), "p < 2")

endmodule

// File: tb/tone_checker.sv
module tone_checker
  import dwtg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_stall,
  input  logic [FREQ_W-1:0]       tone_freq,
  input  logic                    tone_start,
  input  logic                    smp_valid,
  input  logic                    smp_stall,
  input  logic signed [SMP_W-1:0] sine_sample,
  input  logic signed [SMP_W-1:0] circle_sample,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [SMP_W-1:0] sine;
    logic signed [SMP_W-1:0] circ;
  } stereo_t;

  stereo_t expected_samples[$];

  // predictor copy of the generator state
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] circ_pos;
  logic [HP_W-1:0]    half_per;
  logic [FREQ_W-1:0]  cur_freq;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // quarter-wave folded Horner sine, Q30
  function automatic logic signed [SMP_W-1:0] sine_of(input longint unsigned q);
    longint unsigned a, a2, t, s, mag;
    logic neg;
    longint unsigned divs[5];
    divs = '{110, 72, 42, 20, 6};
    neg = 0;
    if (q >= 352800) begin
      neg = 1;
      q = q - 352800;
    end
    if (q > 176400) q = 352800 - q;
    a = (q * 64'd1686629713) / 64'd176400;
    a2 = (a * a) >> 30;
    t = (64'd1 << 30) - a2 / 156;
    for (int i = 0; i < 5; i++) t = (64'd1 << 30) - ((a2 * t) >> 30) / divs[i];
    s = (a * t) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    mag = (64'd32760 * s) >> 30;
    return neg ? -SMP_W'(mag) : SMP_W'(mag);
  endfunction

  function automatic logic signed [SMP_W-1:0] circle_of(input longint unsigned x,
                                                        input longint unsigned p);
    longint unsigned m, r, h;
    longint d;
    m = x * (2 * p - x);
    r = (m << 26) / (p * p);
    h = int_sqrt(r << 26);
    d = longint'(64'd65520 * h) - (longint'(32760) << 26);
    if (d >= 0) return SMP_W'(d >>> 26);
    return -SMP_W'((-d) >>> 26);
  endfunction

  function automatic stereo_t next_sample(input logic [FREQ_W-1:0] f, input logic st);
    stereo_t o;
    longint unsigned span, pa;
    o = '0;
    if (st) begin
      cur_freq = f;
      half_per = (f != 0) ? HP_W'(352800 / f) : '0;
      phase_acc = '0;
      circ_pos = '0;
    end
    if (cur_freq != 0 && half_per >= 2) begin
      span = 2 * longint'(half_per);
      if (circ_pos >= span) circ_pos = '0;
      if (phase_acc >= PHASE_MOD) phase_acc = '0;
      o.sine = sine_of(phase_acc);
      o.circ = circle_of(circ_pos, half_per);
      pa = longint'(phase_acc) + cur_freq;
      if (pa >= 705600) pa = pa - 705600;
      phase_acc = PHASE_W'(pa);
      circ_pos = circ_pos + 1;
      if (circ_pos >= span) circ_pos = '0;
    end
    return o;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stereo_t e;
    if (rst) begin
      phase_acc = '0;
      circ_pos = '0;
      half_per = '0;
      cur_freq = '0;
      expected_samples.delete();
      fail_count = 0;
    end else begin
      // compare output before queueing, so a same-edge item cannot match itself
      if (smp_valid && !smp_stall) begin
        if (expected_samples.size() == 0) begin
          report("unexpected item", sine_sample, 0);
        end else begin
          e = expected_samples.pop_front();
          if (sine_sample !== e.sine) report("sine_sample", sine_sample, e.sine);
          if (circle_sample !== e.circ) report("circle_sample", circle_sample, e.circ);
        end
      end
      if (req_valid && !req_stall)
        expected_samples.insert(expected_samples.size(), next_sample(tone_freq, tone_start));
    end
    pending = expected_samples.size();
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import dwtg_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  logic [FREQ_W-1:0] tone_freq = '0;
  logic tone_start = 0;
  logic smp_valid;
  logic smp_stall = 0;
  logic signed [SMP_W-1:0] sine_sample, circle_sample;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  int quiet = 0;

  always #1 clk = ~clk;

  dual_waveform_tone_generator_top u_dut (.*);

  tone_checker u_chk (.*);

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      smp_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      smp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (smp_valid && !smp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("dual_waveform_tone_generator_top verification failed");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back items and drops only while idling
  task automatic send_item(input logic [FREQ_W-1:0] f, input logic st);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    tone_freq <= f;
    tone_start <= st;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // well-formed tone: a start then a run of continuation items with noise freq
  task automatic send_tone(input logic [FREQ_W-1:0] f, input int len);
    send_item(f, 1);
    for (int i = 1; i < len; i++) send_item(FREQ_W'($urandom), 0);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(9))
      0: return '0;
      1: return FREQ_W'($urandom);
      2: return FREQ_W'($urandom_range(128000, 122000));
      default: return FREQ_W'($urandom_range(128000, 1));
    endcase
  endfunction

  task automatic random_phase(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      int len;
      if ($urandom_range(9) == 0) begin
        send_item(FREQ_W'($urandom), $urandom_range(1));
        sent++;
      end else begin
        len = $urandom_range(30, 1);
        send_tone(pick_freq(), len);
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed: before any start, silence, extremes, wrap, ignored freq change
    send_item(17'd1000, 0);
    send_item(17'h1FFFF, 0);
    send_tone(17'd0, 2);
    send_tone(17'd1, 3);
    send_tone(17'd128000, 4);
    send_tone(17'h1FFFF, 4);
    send_tone(17'd88200, 2);
    send_tone(17'd70560, 6);
    send_item(17'h0AAAA, 0);
    send_item(17'h15555, 0);
    // long receiver hold-off while items keep coming
    hold_off <= 1000;
    send_tone(17'd7040, 5);
    send_idle = 28;
    recv_idle = 83;
    random_phase(170);
    send_idle = 83;
    recv_idle = 28;
    random_phase(170);
    send_idle = 0;
    recv_idle = 0;
    random_phase(180);
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0) $display("dual_waveform_tone_generator_top verification clean");
    else $display("dual_waveform_tone_generator_top verification failed");
    $finish;
  end

endmodule
